[design/tpaf_pkg.sv]
// ----------------------------------------------------------------------------
// tpaf_pkg
// Shared types, codes and constants of the triac phase-angle firing block.
// ----------------------------------------------------------------------------
package tpaf_pkg;

    localparam int DELAY_W   = 14;
    localparam int PERCENT_W = 7;
    localparam int PULSE_W   = 10;

    localparam logic [DELAY_W-1:0]   DELAY_OFF    = 14'd10000;
    localparam logic [DELAY_W-1:0]   DELAY_SKIP   = 14'd9800;
    localparam logic [DELAY_W-1:0]   DELAY_FULL   = 14'd0;
    localparam logic [PERCENT_W-1:0] FULL_PERCENT = 7'd100;
    localparam logic [PERCENT_W-1:0] PHASE_TOP    = 7'd47;
    localparam logic [PERCENT_W-1:0] RESET_HOLD   = 7'd80;
    localparam logic [PULSE_W-1:0]   RESET_PULSE  = 10'd50;

    // Item kinds carried on the input tuser.
    typedef enum logic [1:0] {
        FUNC_TICK      = 2'd0,
        FUNC_CROSS     = 2'd1,
        FUNC_SET_POWER = 2'd2
    } func_t;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_PULSE_WIDTH = 1'b0,
        REG_LATCH_HOLD  = 1'b1
    } reg_idx_t;

    // Firing delay for 0..47 percent: 9100 - floor(p * 3600 / 47).
    localparam logic [DELAY_W-1:0] PHASE_DELAY_TABLE [48] = '{
        14'd9100, 14'd9024, 14'd8947, 14'd8871, 14'd8794, 14'd8718,
        14'd8641, 14'd8564, 14'd8488, 14'd8411, 14'd8335, 14'd8258,
        14'd8181, 14'd8105, 14'd8028, 14'd7952, 14'd7875, 14'd7798,
        14'd7722, 14'd7645, 14'd7569, 14'd7492, 14'd7415, 14'd7339,
        14'd7262, 14'd7186, 14'd7109, 14'd7032, 14'd6956, 14'd6879,
        14'd6803, 14'd6726, 14'd6649, 14'd6573, 14'd6496, 14'd6420,
        14'd6343, 14'd6266, 14'd6190, 14'd6113, 14'd6037, 14'd5960,
        14'd5883, 14'd5807, 14'd5730, 14'd5654, 14'd5577, 14'd5500
    };

    typedef struct packed {
        logic [PULSE_W-1:0]   pulse_width;
        logic [PERCENT_W-1:0] latch_hold;
    } cfg_t;

    typedef struct packed {
        logic                 latch;
        logic [PERCENT_W-1:0] applied;
        logic [DELAY_W-1:0]   delay;
    } power_t;

    typedef struct packed {
        logic                 gate;
        logic                 fired;
        logic [PERCENT_W-1:0] applied_power;
        logic [DELAY_W-1:0]   delay_us;
    } result_t;

endpackage

[design/tpaf_power_map.sv]
// ----------------------------------------------------------------------------
// tpaf_power_map
// Maps a requested power percent to applied percent, firing delay and latch.
// ----------------------------------------------------------------------------
module tpaf_power_map
    import tpaf_pkg::*;
(
    input  logic signed [7:0]     percent,
    input  logic                  latch,
    input  logic [PERCENT_W-1:0]  latch_hold,
    input  power_t                current,
    output power_t                mapped
);

    logic                 is_off;
    logic                 is_full;
    logic                 holds;
    logic [PERCENT_W-1:0] clamped;

    always_comb
    begin
        is_off  = percent[7] || (percent == 8'sd0);
        is_full = !percent[7] && (percent[6:0] >= FULL_PERCENT);
        // Positive percent below 100 fits in seven bits.
        holds   = latch && (percent[6:0] >= latch_hold);
        clamped = (percent[6:0] > PHASE_TOP) ? PHASE_TOP : percent[6:0];

        mapped = current;
        if (is_off)
        begin
            mapped.latch   = 1'b0;
            mapped.applied = '0;
            mapped.delay   = DELAY_OFF;
        end
        else if (is_full || holds)
        begin
            mapped.latch   = 1'b1;
            mapped.applied = FULL_PERCENT;
            mapped.delay   = DELAY_FULL;
        end
        else
        begin
            mapped.latch   = 1'b0;
            mapped.applied = clamped;
            mapped.delay   = PHASE_DELAY_TABLE[clamped[5:0]];
        end
    end

endmodule

[design/tpaf_engine.sv]
// ----------------------------------------------------------------------------
// tpaf_engine
// Firing state and the update applied by each request.
// ----------------------------------------------------------------------------
module tpaf_engine
    import tpaf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [1:0]        func,
    input  logic signed [7:0] percent,
    input  cfg_t              cfg,
    output result_t           result
);

    power_t               power_reg, power_next, mapped;
    logic [DELAY_W-1:0]   countdown_reg, countdown_next;
    logic                 counting_reg, counting_next;
    logic [PULSE_W-1:0]   pulse_left_reg, pulse_left_next;
    logic                 gate_reg, gate_next;
    logic                 fired;
    logic [DELAY_W-1:0]   count_dec;
    logic [PULSE_W-1:0]   pulse_load;

    tpaf_power_map u_power_map (
        .percent    (percent),
        .latch      (power_reg.latch),
        .latch_hold (cfg.latch_hold),
        .current    (power_reg),
        .mapped     (mapped)
    );

    always_comb
    begin
        power_next      = power_reg;
        countdown_next  = countdown_reg;
        counting_next   = counting_reg;
        pulse_left_next = pulse_left_reg;
        gate_next       = gate_reg;
        fired           = 1'b0;
        count_dec       = (countdown_reg != '0) ? countdown_reg - 1'b1 : countdown_reg;
        pulse_load      = (cfg.pulse_width != '0) ? cfg.pulse_width : PULSE_W'(1);

        case (func)
            FUNC_SET_POWER:
            begin
                power_next = mapped;
            end
            FUNC_CROSS:
            begin
                counting_next   = 1'b0;
                countdown_next  = '0;
                pulse_left_next = '0;
                gate_next       = 1'b0;
                if (power_reg.delay == DELAY_FULL)
                begin
                    gate_next = 1'b1;
                    fired     = 1'b1;
                end
                else if (power_reg.delay < DELAY_SKIP)
                begin
                    countdown_next = power_reg.delay;
                    counting_next  = 1'b1;
                end
            end
            FUNC_TICK:
            begin
                if (pulse_left_reg != '0)
                begin
                    pulse_left_next = pulse_left_reg - 1'b1;
                    if (pulse_left_reg == PULSE_W'(1))
                    begin
                        gate_next = 1'b0;
                    end
                end
                else if (counting_reg)
                begin
                    countdown_next = count_dec;
                    if (count_dec == '0)
                    begin
                        counting_next   = 1'b0;
                        gate_next       = 1'b1;
                        pulse_left_next = pulse_load;
                        fired           = 1'b1;
                    end
                end
            end
            default:
            begin
                // Unused kind: state holds and nothing fires.
            end
        endcase

        result.gate          = gate_next;
        result.fired         = fired;
        result.applied_power = power_next.applied;
        result.delay_us      = power_next.delay;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg      <= '{latch: 1'b0, applied: '0, delay: DELAY_OFF};
            countdown_reg  <= '0;
            counting_reg   <= 1'b0;
            pulse_left_reg <= '0;
            gate_reg       <= 1'b0;
        end
        else if (step)
        begin
            power_reg      <= power_next;
            countdown_reg  <= countdown_next;
            counting_reg   <= counting_next;
            pulse_left_reg <= pulse_left_next;
            gate_reg       <= gate_next;
        end
    end

    // A running gate pulse keeps the gate high.
    a_pulse_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (pulse_left_reg != '0) |-> gate_reg)
        else $error("gate low while a pulse is running");

    // The phase countdown and the gate pulse never run together.
    a_count_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(counting_reg && (pulse_left_reg != '0)))
        else $error("countdown and pulse active together");

    // An armed countdown always has ticks left.
    a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
        counting_reg |-> (countdown_reg != '0))
        else $error("countdown armed at zero");

    // A firing request always leaves the gate high.
    a_fire_gate: assert property (@(posedge clk) disable iff (!rst_n)
        (step && fired) |=> gate_reg)
        else $error("fired without raising the gate");

endmodule

[design/triac_phase_angle_firing_top.sv]
// Path: an accepted request waits in the input register, its result in the result register.
// Throughput: one request per cycle while the master side keeps taking results.
// Stalls on the master side back up through the input register to s_tready.
// Reset (rst_n, asynchronous, active low) clears the pipeline, the firing state
// and loads the registers with a pulse width of 50 and a latch hold of 80 percent.
// ----------------------------------------------------------------------------
// triac_phase_angle_firing_top
// Triac phase-angle firing controller with stream ports and a register port.
// ----------------------------------------------------------------------------
module triac_phase_angle_firing_top
    import tpaf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Slave side: one request per transfer.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] percent (signed)
    input  logic [1:0]  s_tuser,   // [1:0] func
    // Master side: one result per request.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] gate, [1] fired, [8:2] applied_power,
                                   // [22:9] delay_us, [23] zero
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The input register holds the accepted request; the engine updates its
    // state from it and the result register holds the outcome until the
    // master side takes it. Both registers may be full at once, so a new
    // request is taken even while a result is still waiting.
    logic              in_valid_reg, in_valid_next;
    logic [1:0]        in_func_reg;
    logic signed [7:0] in_percent_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_result_reg;
    result_t           result;
    logic              advance;
    logic              take;
    cfg_t              cfg_reg, cfg_next;
    logic              cfg_write;

    // The request in the input register moves on when the result slot is
    // empty or is being emptied in this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_func_reg    <= s_tuser;
            in_percent_reg <= s_tdata;
        end
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    tpaf_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .func    (in_func_reg),
        .percent (in_percent_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_result_reg.delay_us, out_result_reg.applied_power,
                       out_result_reg.fired, out_result_reg.gate};

    // Register port: always ready, writes land on the access cycle. The
    // register is selected by address bit two, so each register occupies a
    // four-byte slot.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_PULSE_WIDTH: cfg_next.pulse_width = pwdata[PULSE_W-1:0];
                REG_LATCH_HOLD:  cfg_next.latch_hold  = pwdata[PERCENT_W-1:0];
            endcase
        end

        unique case (reg_idx_t'(paddr[2]))
            REG_PULSE_WIDTH: prdata = {{(32-PULSE_W){1'b0}}, cfg_reg.pulse_width};
            REG_LATCH_HOLD:  prdata = {{(32-PERCENT_W){1'b0}}, cfg_reg.latch_hold};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{pulse_width: RESET_PULSE, latch_hold: RESET_HOLD};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[tb/triac_phase_angle_firing_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// triac_phase_angle_firing_top_tb
// Self-checking bench for the triac phase-angle firing controller. Requests
// go in on the slave stream and are predicted in the bench. Each result on
// the master stream is checked field by field against the oldest
// prediction. Both streams idle and stall at random.
// ----------------------------------------------------------------------------
module triac_phase_angle_firing_top_tb
    import tpaf_pkg::*;
();

    localparam int          HALF_PERIOD_NS   = 6;
    localparam int          RESET_CYCLES     = 7;
    localparam int          SETTLE_CYCLES    = 6;
    localparam int          LONG_HOLD_CYCLES = 300;
    localparam int          RANDOM_ITEMS     = 1100;
    localparam longint      TIMEOUT_NS       = 64'd20_000_000;
    localparam int          PHASE_START_US   = 9100;
    localparam int          PHASE_SPAN_US    = 3600;
    localparam logic [1:0]  FUNC_UNUSED      = 2'd3;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [7:0] percent (signed)
    logic [1:0]  s_tuser  = 2'd0;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // [0] gate, [1] fired, [8:2] applied_power,
                                    // [22:9] delay_us, [23] zero
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    triac_phase_angle_firing_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #HALF_PERIOD_NS clk = 1'b1;
        #HALF_PERIOD_NS clk = 1'b0;
    end

    // The bench's own view of the controller: register copies and firing state.
    logic [PULSE_W-1:0]   pulse_width_reg = RESET_PULSE;
    logic [PERCENT_W-1:0] latch_hold_reg  = RESET_HOLD;
    logic [DELAY_W-1:0]   firing_delay_us = DELAY_OFF;
    logic [PERCENT_W-1:0] applied_pct     = '0;
    logic                 full_latch      = 1'b0;
    logic [DELAY_W-1:0]   countdown_us    = '0;
    logic                 counting        = 1'b0;
    logic [PULSE_W-1:0]   pulse_left      = '0;
    logic                 gate_level      = 1'b0;

    // Results still owed by the block, oldest first.
    result_t firing_results_due[$];

    int  failures      = 0;
    int  random_sent   = 0;
    bit  sender_gaps_on = 1'b1;
    int  burst_left    = 0;
    int  hold_requests = 0;
    int  hold_served   = 0;
    int  hold_off_left = 0;
    bit [31:0] rx_cycle = '0;

    // Applies one request to the bench's firing state and returns the result
    // the block must report for it.
    function automatic result_t predict_firing_result(logic [1:0] func,
                                                      logic signed [7:0] pct);
        result_t res;
        int      p;
        logic    fired;

        fired = 1'b0;
        p     = pct;
        if (func == FUNC_SET_POWER)
        begin
            if (p <= 0)
            begin
                full_latch      = 1'b0;
                applied_pct     = '0;
                firing_delay_us = DELAY_OFF;
            end
            else if (p >= int'(FULL_PERCENT))
            begin
                full_latch      = 1'b1;
                applied_pct     = FULL_PERCENT;
                firing_delay_us = DELAY_FULL;
            end
            else if (full_latch && p >= int'(latch_hold_reg))
            begin
                applied_pct     = FULL_PERCENT;
                firing_delay_us = DELAY_FULL;
            end
            else
            begin
                // Phase control saturates at the top of its range; the
                // delay falls linearly and truncates towards zero.
                full_latch = 1'b0;
                if (p > int'(PHASE_TOP))
                    p = int'(PHASE_TOP);
                applied_pct     = PERCENT_W'(p);
                firing_delay_us = DELAY_W'(PHASE_START_US
                                           - (p * PHASE_SPAN_US) / int'(PHASE_TOP));
            end
        end
        else if (func == FUNC_CROSS)
        begin
            counting     = 1'b0;
            countdown_us = '0;
            pulse_left   = '0;
            gate_level   = 1'b0;
            if (firing_delay_us == DELAY_FULL)
            begin
                gate_level = 1'b1;
                fired      = 1'b1;
            end
            else if (firing_delay_us < DELAY_SKIP)
            begin
                countdown_us = firing_delay_us;
                counting     = 1'b1;
            end
        end
        else if (func == FUNC_TICK)
        begin
            if (pulse_left != 0)
            begin
                pulse_left--;
                if (pulse_left == 0)
                    gate_level = 1'b0;
            end
            else if (counting)
            begin
                if (countdown_us != 0)
                    countdown_us--;
                if (countdown_us == 0)
                begin
                    counting   = 1'b0;
                    gate_level = 1'b1;
                    pulse_left = (pulse_width_reg == 0) ? PULSE_W'(1) : pulse_width_reg;
                    fired      = 1'b1;
                end
            end
        end

        res.gate          = gate_level;
        res.fired         = fired;
        res.applied_power = applied_pct;
        res.delay_us      = firing_delay_us;
        return res;
    endfunction

    // Offers one request, waits for its acceptance and records its result.
    // When gaps are on, the sender drops valid between bursts.
    task automatic send_request(logic [1:0] func, logic [7:0] pct);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= pct;
        do
            @(posedge clk);
        while (!s_tready);
        firing_results_due.push_back(predict_firing_result(func, pct));
        if (func != FUNC_UNUSED)
            random_sent++;
        if (sender_gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 32);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    task automatic send_ticks(int count);
        repeat (count)
            send_request(FUNC_TICK, 8'($urandom));
    endtask

    // Stops offering and waits until every owed result has been taken.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (firing_results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Writes a register while the block is idle, then reads it back.
    task automatic program_register(reg_idx_t idx, int unsigned value);
        logic [31:0] want;

        wait_for_results();
        if (idx == REG_PULSE_WIDTH)
        begin
            pulse_width_reg = PULSE_W'(value);
            want            = 32'(pulse_width_reg);
        end
        else
        begin
            latch_hold_reg = PERCENT_W'(value);
            want           = 32'(latch_hold_reg);
        end

        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= want;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;

        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            $error("register %s readback: expected %0d, got %0d", idx.name(), want, prdata);
            failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // After reset the delay is off: a crossing and ticks leave the gate low,
    // and the unused selector changes nothing.
    task automatic test_idle_after_reset();
        send_request(FUNC_CROSS, 8'h00);
        send_request(FUNC_TICK, 8'hFF);
        send_request(FUNC_UNUSED, 8'h7F);
        send_request(FUNC_UNUSED, 8'h80);
        send_request(FUNC_SET_POWER, 8'h00);
        send_request(FUNC_CROSS, 8'h55);
    endtask

    // Percent extremes, the phase clamp and the full-power latch at its
    // default hold level.
    task automatic test_power_mapping();
        send_request(FUNC_SET_POWER, 8'h80);
        send_request(FUNC_SET_POWER, 8'hFF);
        send_request(FUNC_SET_POWER, 8'd1);
        send_request(FUNC_SET_POWER, 8'd46);
        send_request(FUNC_SET_POWER, 8'd47);
        send_request(FUNC_SET_POWER, 8'd48);
        send_request(FUNC_SET_POWER, 8'd99);
        send_request(FUNC_SET_POWER, 8'd127);
        send_request(FUNC_SET_POWER, 8'd80);   // latched, at the hold level
        send_request(FUNC_SET_POWER, 8'd79);   // below it: the latch lets go
        send_request(FUNC_SET_POWER, 8'd90);   // no latch any more, so clamped
        send_request(FUNC_SET_POWER, 8'd100);
        send_request(FUNC_SET_POWER, 8'd0);
    endtask

    // At full power the crossing itself fires and holds the gate high; ticks
    // leave it alone until the next crossing.
    task automatic test_full_on_crossing();
        send_request(FUNC_SET_POWER, 8'd100);
        send_request(FUNC_CROSS, 8'h00);
        send_ticks(5);
        send_request(FUNC_CROSS, 8'h00);
        send_request(FUNC_SET_POWER, 8'd0);
        send_request(FUNC_CROSS, 8'h00);
    endtask

    // Register extremes: hold levels of 1 and 100, and pulse widths of zero,
    // the maximum and one, the last two written while a phase countdown is running.
    task automatic test_register_extremes();
        program_register(REG_LATCH_HOLD, 1);
        send_request(FUNC_SET_POWER, 8'd100);
        send_request(FUNC_SET_POWER, 8'd1);
        send_request(FUNC_SET_POWER, 8'd0);
        program_register(REG_LATCH_HOLD, 100);
        send_request(FUNC_SET_POWER, 8'd100);
        send_request(FUNC_SET_POWER, 8'd99);
        send_request(FUNC_SET_POWER, 8'd100);
        send_request(FUNC_SET_POWER, 8'd100);

        program_register(REG_PULSE_WIDTH, 0);
        send_request(FUNC_SET_POWER, 8'd47);
        send_request(FUNC_CROSS, 8'h00);
        send_ticks(3);

        program_register(REG_PULSE_WIDTH, 1023);
        send_request(FUNC_CROSS, 8'h00);
        send_ticks(3);

        program_register(REG_PULSE_WIDTH, 1);
        send_request(FUNC_CROSS, 8'h00);
        send_ticks(2);
    endtask

    // A crossing in the middle of a countdown restarts it, and a power
    // request during the countdown leaves it running. At full power a second
    // crossing drops the held gate and fires again.
    task automatic test_crossing_during_countdown();
        program_register(REG_PULSE_WIDTH, 50);
        program_register(REG_LATCH_HOLD, 80);
        send_request(FUNC_SET_POWER, 8'd47);
        send_request(FUNC_CROSS, 8'h00);
        send_ticks(100);
        send_request(FUNC_SET_POWER, 8'd1);
        send_ticks(50);
        send_request(FUNC_CROSS, 8'h00);
        send_ticks(3);
        send_request(FUNC_SET_POWER, 8'd100);
        send_request(FUNC_CROSS, 8'h00);
        send_ticks(3);
        send_request(FUNC_CROSS, 8'h00);
        send_request(FUNC_SET_POWER, 8'd0);
    endtask

    // The receiver holds off for a long stretch while the sender keeps on
    // offering, so the block fills up and stalls its input.
    task automatic test_output_backpressure();
        wait_for_results();
        sender_gaps_on = 1'b0;
        hold_requests++;
        repeat (40)
            send_request(2'($urandom_range(0, 3)), 8'($urandom));
        sender_gaps_on = 1'b1;
        wait_for_results();
    endtask

    // Mostly well-formed half waves with random content: an optional power
    // request, a crossing and a short run of ticks, and a few waves of pure
    // noise. Phase delays run to thousands of ticks, so the runs stay inside
    // the countdown.
    task automatic test_random_half_waves();
        int          wave;
        int          kind;
        int          sel;
        int          neg;
        int          n;
        int          mid;
        logic [7:0]  pct;

        wave        = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            wave++;
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            if (wave % 25 == 0)
            begin
                program_register(REG_PULSE_WIDTH, ($urandom_range(0, 3) == 0)
                                 ? $urandom_range(1, 1023) : $urandom_range(1, 64));
                program_register(REG_LATCH_HOLD, $urandom_range(1, 100));
            end
            else if (wave % 17 == 0)
            begin
                wait_for_results();
            end
            else if (wave % 41 == 0)
            begin
                hold_requests++;
            end

            kind = $urandom_range(0, 99);
            if (kind < 8)
            begin
                repeat ($urandom_range(1, 6))
                    send_request(2'($urandom_range(0, 3)), 8'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    sel = $urandom_range(0, 19);
                    if (sel < 4)
                    begin
                        pct = 8'($urandom);
                    end
                    else if (sel < 14)
                    begin
                        pct = 8'($urandom_range(40, 99));
                    end
                    else if (sel < 17)
                    begin
                        pct = 8'($urandom_range(100, 127));
                    end
                    else
                    begin
                        neg = $urandom_range(0, 128);
                        pct = 8'(-neg);
                    end
                    send_request(FUNC_SET_POWER, pct);
                end
                send_request(FUNC_CROSS, 8'($urandom));
                if (counting)
                begin
                    n   = $urandom_range(0, 40);
                    mid = $urandom_range(0, n);
                    send_ticks(mid);
                    if ($urandom_range(0, 5) == 0)
                        send_request(FUNC_SET_POWER, 8'($urandom));
                    send_ticks(n - mid);
                end
                else
                begin
                    send_ticks($urandom_range(0, 12));
                end
            end
        end
        sender_gaps_on = 1'b1;
    endtask

    // Receiver: bits 9:8 of its cycle counter pick the readiness pattern: always
    // ready, coin-flip stalls, a fixed one-in-four stall or light random
    // stalls. A hold-off request overrides the pattern for a long stretch.
    always @(posedge clk)
    begin
        rx_cycle++;
        if (hold_served != hold_requests)
        begin
            hold_served   = hold_requests;
            hold_off_left = LONG_HOLD_CYCLES;
        end
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_off_left != 0)
        begin
            hold_off_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_cycle[9:8])
                2'd0:    m_tready <= 1'b1;
                2'd1:    m_tready <= ($urandom_range(0, 1) == 0);
                2'd2:    m_tready <= (rx_cycle[1:0] != 2'b11);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Result checker: every accepted result is matched against the oldest
    // prediction, field by field.
    always @(posedge clk)
    begin
        result_t want;

        if (rst_n && m_tvalid && m_tready)
        begin
            if (firing_results_due.size() == 0)
            begin
                $error("result with no request outstanding: m_tdata %h", m_tdata);
                failures++;
            end
            else
            begin
                want = firing_results_due.pop_front();
                if (m_tdata[0] !== want.gate)
                begin
                    $error("gate: expected %0d, got %0d", want.gate, m_tdata[0]);
                    failures++;
                end
                if (m_tdata[1] !== want.fired)
                begin
                    $error("fired: expected %0d, got %0d", want.fired, m_tdata[1]);
                    failures++;
                end
                if (m_tdata[8:2] !== want.applied_power)
                begin
                    $error("applied_power: expected %0d, got %0d",
                           want.applied_power, m_tdata[8:2]);
                    failures++;
                end
                if (m_tdata[22:9] !== want.delay_us)
                begin
                    $error("delay_us: expected %0d, got %0d", want.delay_us, m_tdata[22:9]);
                    failures++;
                end
                if (m_tdata[23] !== 1'b0)
                begin
                    $error("pad bit: expected 0, got %b", m_tdata[23]);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("triac_phase_angle_firing_top_tb NOT OK");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_after_reset();
        test_power_mapping();
        test_full_on_crossing();
        test_register_extremes();
        test_crossing_during_countdown();
        test_output_backpressure();
        test_random_half_waves();

        wait_for_results();
        if (firing_results_due.size() != 0)
            failures++;
        if (failures == 0)
            $display("triac_phase_angle_firing_top_tb OK");
        else
            $display("triac_phase_angle_firing_top_tb NOT OK");
        $finish;
    end

endmodule
